// ===== rtl/rmfe_pkg.sv =====
// Package for the relativistic momentum pipeline: widths, stage positions,
// sine polynomial coefficients and the lane types shared by the datapath.
// No dependencies.
package rmfe_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned A_W    = 8;
  localparam int unsigned E_W    = 24;
  localparam int unsigned NM_W   = 24;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned MOM_W  = 33;
  localparam int unsigned BETA_W = 17;
  localparam int unsigned ADDR_W = 3;

  localparam logic [NM_W-1:0] NM_RESET = 24'd240198;

  // register word index (paddr[2])
  localparam logic IDX_NM = 1'b0;

  // Q30 trig constants
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [61:0] HALF_Q30 = 62'h2000_0000;

  localparam logic [30:0] SIN_COEF [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569306,
    31'd5026995,    31'd172272,    31'd3864
  };

  // widths of the magnitude path
  localparam int unsigned T_W    = 32;  // kinetic and rest energy
  localparam int unsigned TOT_W  = 33;  // T + m
  localparam int unsigned S2M_W  = 34;  // T + 2m
  localparam int unsigned N_W    = 66;  // T * (T + 2m)
  localparam int unsigned P_W    = 33;  // root
  localparam int unsigned DR_W   = 34;  // divider remainder

  // stage positions (register index after each stage)
  localparam int unsigned ST_SQ0   = 4;   // radicand formed
  localparam int unsigned SQ_STEPS = 33;
  localparam int unsigned ST_ROOT  = ST_SQ0 + SQ_STEPS;  // 37
  localparam int unsigned ST_FAC   = 9;   // trig factors formed
  localparam int unsigned ST_PP    = ST_ROOT + 1;       // 38 partial products
  localparam int unsigned ST_MAG   = ST_ROOT + 2;       // 39
  localparam int unsigned ST_MOM   = ST_ROOT + 3;       // 40
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned ST_OUT   = ST_ROOT + DIV_STEPS;  // 54

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] u;
    logic [30:0] u2;
    logic [30:0] poly;
  } sin_lane_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } trig_t;

endpackage

// ===== rtl/relativistic_momentum_from_energy.sv =====
// Throughput: one word per cycle; a stall at the output holds the whole pipe.
// Pipeline depth is set by the 33-step root stages and the 17-step divider for beta.
// Reset empties the pipeline and returns nucleon_mass to 240198 (1/256 MeV).
// Depends on rmfe_pkg.
module relativistic_momentum_from_energy #(
  parameter int unsigned ANGLE_BITS = rmfe_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rmfe_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rmfe_pkg::A_W-1:0]           mass_number_i,
  input  logic [rmfe_pkg::E_W-1:0]           energy_per_nucleon_i,
  input  logic [rmfe_pkg::ANG_W-1:0]         azimuth_angle_i,
  input  logic [rmfe_pkg::ANG_W-1:0]         polar_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rmfe_pkg::MOM_W-1:0]  momentum_x_o,
  output logic signed [rmfe_pkg::MOM_W-1:0]  momentum_y_o,
  output logic signed [rmfe_pkg::MOM_W-1:0]  momentum_z_o,
  output logic [rmfe_pkg::BETA_W-1:0]        beta_value_o
);
  import rmfe_pkg::*;

  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int unsigned PH_SH = 32 - ANGLE_BITS;

  // ---------------- configuration ----------------
  logic [NM_W-1:0] nm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_q <= NM_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == IDX_NM)) begin
      nm_q <= pwdata[NM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == IDX_NM) ? {8'd0, nm_q} : 32'd0;

  // ---------------- pipeline control ----------------
  logic              en;
  logic [ST_OUT:1]   vld_q;

  assign en         = !vld_q[ST_OUT] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:1], in_valid_i};
    end
  end

  // ---------------- energies and radicand ----------------
  logic [T_W-1:0]   m1_q, t1_q, t2_q;
  logic [TOT_W-1:0] tot_q [2:ST_OUT-1];
  logic [S2M_W-1:0] s2m2_q;
  logic [48:0]      pplo3_q, pphi3_q;
  logic [N_W-1:0]   rem_q  [ST_SQ0:ST_ROOT];
  logic [P_W-1:0]   root_q [ST_SQ0:ST_ROOT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q    <= T_W'(mass_number_i * nm_q);
      t1_q    <= T_W'(mass_number_i * energy_per_nucleon_i);
      tot_q[2] <= TOT_W'(t1_q) + TOT_W'(m1_q);
      s2m2_q  <= S2M_W'(t1_q) + {1'b0, m1_q, 1'b0};
      t2_q    <= t1_q;
      pplo3_q <= 49'(t2_q * s2m2_q[16:0]);
      pphi3_q <= 49'(t2_q * s2m2_q[33:17]);
      rem_q[ST_SQ0]  <= N_W'(pplo3_q) + N_W'({pphi3_q, 17'd0});
      root_q[ST_SQ0] <= '0;
    end
  end

  for (genvar s = 3; s <= ST_OUT - 1; s++) begin : g_tot
    always_ff @(posedge clk_i) begin
      if (en) tot_q[s] <= tot_q[s-1];
    end
  end

  // square root, one root bit per stage: R -= (r << (b+1)) | (1 << 2b)
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int unsigned B = SQ_STEPS - 1 - k;
    logic [66:0] trial;
    logic        take;
    always_comb begin
      trial = (67'(root_q[ST_SQ0+k]) << (B + 1)) | (67'd1 << (2 * B));
      take  = {1'b0, rem_q[ST_SQ0+k]} >= trial;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[ST_SQ0+k+1]  <= take ? N_W'({1'b0, rem_q[ST_SQ0+k]} - trial)
                                   : rem_q[ST_SQ0+k];
        root_q[ST_SQ0+k+1] <= take ? (root_q[ST_SQ0+k] | (P_W'(1) << B))
                                   : root_q[ST_SQ0+k];
      end
    end
  end

  // ---------------- sines: lanes cos az, sin az, cos pol, sin pol ----------------
  sin_lane_t sl_q [1:7][4];
  sin_lane_t sl1_d [4];
  trig_t     tg_q [4];
  trig_t     fac_q [ST_FAC:ST_ROOT][3];
  logic [31:0] ph_az, ph_pol;
  logic [31:0] lane_ph [4];

  always_comb begin
    ph_az  = (32'(azimuth_angle_i) & AMASK) << PH_SH;
    ph_pol = (32'(polar_angle_i) & AMASK) << PH_SH;
    lane_ph[0] = ph_az + 32'h4000_0000;
    lane_ph[1] = ph_az;
    lane_ph[2] = ph_pol + 32'h4000_0000;
    lane_ph[3] = ph_pol;
    for (int l = 0; l < 4; l++) begin
      sl1_d[l].quad = lane_ph[l][31:30];
      sl1_d[l].u    = lane_ph[l][30] ? ONE_Q30 - {1'b0, lane_ph[l][29:0]}
                                     : {1'b0, lane_ph[l][29:0]};
      sl1_d[l].u2   = '0;
      sl1_d[l].poly = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        sl_q[1][l]      <= sl1_d[l];
        sl_q[2][l].quad <= sl_q[1][l].quad;
        sl_q[2][l].u    <= sl_q[1][l].u;
        sl_q[2][l].u2   <= 31'(62'(sl_q[1][l].u * sl_q[1][l].u) >> 30);
        sl_q[2][l].poly <= SIN_COEF[5];
      end
    end
  end

  // Horner steps, truncating each product
  for (genvar s = 3; s <= 7; s++) begin : g_horner
    logic [61:0] prod [4];
    always_comb begin
      for (int l = 0; l < 4; l++) prod[l] = sl_q[s-1][l].u2 * sl_q[s-1][l].poly;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          sl_q[s][l].quad <= sl_q[s-1][l].quad;
          sl_q[s][l].u    <= sl_q[s-1][l].u;
          sl_q[s][l].u2   <= sl_q[s-1][l].u2;
          sl_q[s][l].poly <= 31'({1'b0, SIN_COEF[7-s]} - prod[l][61:30]);
        end
      end
    end
  end

  logic [61:0] sprod [4];
  logic [31:0] sval [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sprod[l] = sl_q[7][l].u * sl_q[7][l].poly;
      sval[l]  = sprod[l][61:30];
      if (sval[l] > {1'b0, ONE_Q30}) sval[l] = {1'b0, ONE_Q30};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        tg_q[l].mag <= sval[l][30:0];
        tg_q[l].neg <= sl_q[7][l].quad[1] && (sval[l] != 32'd0);
      end
    end
  end

  // products of trig magnitudes, rounded half up to Q30
  logic [61:0] fx_p, fy_p;
  assign fx_p = (tg_q[0].mag * tg_q[3].mag) + HALF_Q30;
  assign fy_p = (tg_q[1].mag * tg_q[3].mag) + HALF_Q30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fac_q[ST_FAC][0].mag <= fx_p[60:30];
      fac_q[ST_FAC][0].neg <= tg_q[0].neg ^ tg_q[3].neg;
      fac_q[ST_FAC][1].mag <= fy_p[60:30];
      fac_q[ST_FAC][1].neg <= tg_q[1].neg ^ tg_q[3].neg;
      fac_q[ST_FAC][2]     <= tg_q[2];
    end
  end

  for (genvar s = ST_FAC + 1; s <= ST_ROOT; s++) begin : g_fac
    always_ff @(posedge clk_i) begin
      if (en) fac_q[s] <= fac_q[s-1];
    end
  end

  // ---------------- momentum components ----------------
  logic [47:0] cpl_q [3];
  logic [46:0] cph_q [3];
  logic        cneg_q [ST_PP:ST_MAG][3];
  logic [31:0] cmag_q [3];
  logic signed [MOM_W-1:0] mom_q [ST_MOM:ST_OUT][3];
  logic [63:0] csum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = 64'(cpl_q[c]) + {cph_q[c], 17'd0} + 64'(HALF_Q30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        cpl_q[c]          <= 48'(root_q[ST_ROOT][16:0] * fac_q[ST_ROOT][c].mag);
        cph_q[c]          <= 47'(root_q[ST_ROOT][32:17] * fac_q[ST_ROOT][c].mag);
        cneg_q[ST_PP][c]  <= fac_q[ST_ROOT][c].neg;
        cneg_q[ST_MAG][c] <= cneg_q[ST_PP][c];
        cmag_q[c]         <= (csum[c][63:62] != 2'b00) ? 32'hFFFF_FFFF : csum[c][61:30];
        mom_q[ST_MOM][c]  <= cneg_q[ST_MAG][c] ? -$signed({1'b0, cmag_q[c]})
                                               :  $signed({1'b0, cmag_q[c]});
      end
    end
  end

  for (genvar s = ST_MOM + 1; s <= ST_OUT; s++) begin : g_mom
    always_ff @(posedge clk_i) begin
      if (en) mom_q[s] <= mom_q[s-1];
    end
  end

  // ---------------- beta: restoring divide, p*2^16 / (T+m) ----------------
  logic [DR_W-1:0]   dr_q [ST_PP:ST_OUT-1];
  logic [BETA_W-1:0] qd_q [ST_PP:ST_OUT-1];
  logic [BETA_W-1:0] beta_q;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned S = ST_PP + j;
    logic [DR_W-1:0]   cand;
    logic [BETA_W-1:0] qin;
    logic [BETA_W-1:0] qnext;
    logic              take;
    if (j == 0) begin : g_first
      assign cand = DR_W'(root_q[ST_ROOT]);
      assign qin  = '0;
    end else begin : g_next
      assign cand = {dr_q[S-1][DR_W-2:0], 1'b0};
      assign qin  = qd_q[S-1];
    end
    always_comb begin
      take  = cand >= DR_W'(tot_q[S-1]);
      qnext = {qin[BETA_W-2:0], take};
    end
    if (j == DIV_STEPS - 1) begin : g_last
      always_ff @(posedge clk_i) begin
        if (en) beta_q <= (tot_q[S-1] == '0) ? '0 : qnext;
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[S] <= take ? cand - DR_W'(tot_q[S-1]) : cand;
          qd_q[S] <= qnext;
        end
      end
    end
  end

  assign momentum_x_o = mom_q[ST_OUT][0];
  assign momentum_y_o = mom_q[ST_OUT][1];
  assign momentum_z_o = mom_q[ST_OUT][2];
  assign beta_value_o = beta_q;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROOT] |-> (67'(rem_q[ST_ROOT]) <= 67'({root_q[ST_ROOT], 1'b0})))
    else $error("root remainder exceeds 2p");

  a_root_le_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROOT] |-> (root_q[ST_ROOT] <= tot_q[ST_ROOT]))
    else $error("momentum exceeds total energy");

  a_beta_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_OUT] |-> (beta_q <= 17'd65536))
    else $error("beta above one");
`endif

endmodule

// ===== bench/relativistic_momentum_from_energy_tb.sv =====
// Self-checking bench for relativistic_momentum_from_energy: directed table, then random
// particles under several nucleon masses and handshake idling patterns.
// Depends on rmfe_pkg and the block itself.
module relativistic_momentum_from_energy_tb;
  import rmfe_pkg::*;

  localparam int unsigned WATCHDOG = 5000;
  localparam int unsigned TAIL     = 80;
  localparam bit [63:0]   HALF30   = 64'h2000_0000;
  localparam bit [63:0]   ONE30    = 64'h4000_0000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    bit [32:0] px, py, pz;
    bit [16:0] beta;
  } momentum_word_t;

  typedef struct {
    bit [7:0]  a;
    bit [23:0] e;
    bit [15:0] az, pol;
    bit        typed;
    momentum_word_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [A_W-1:0] mass_number_i = '0;
  logic [E_W-1:0] energy_per_nucleon_i = '0;
  logic [ANG_W-1:0] azimuth_angle_i = '0;
  logic [ANG_W-1:0] polar_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [MOM_W-1:0] momentum_x_o, momentum_y_o, momentum_z_o;
  logic [BETA_W-1:0] beta_value_o;

  relativistic_momentum_from_energy dut (.*);

  always #2 clk_i = ~clk_i;

  bit [23:0] nucleon_mass_q = 24'd240198;
  momentum_word_t pending_words[$];
  idle_mode_e idle_mode = IDLE_NONE;
  int hold_left = 0;
  int n_items = 0, n_words = 0, n_errors = 0, n_settings = 0;
  int quiet_cycles = 0;

  bit [63:0] poly_coef [6] = '{64'd1686629713, 64'd693598668, 64'd85569306,
                               64'd5026995, 64'd172272, 64'd3864};

  // sine of a 32-bit turn fraction, Q30 signed
  function automatic longint signed sine_of_turn(bit [31:0] ph);
    bit [63:0] u, u2, t, s;
    u = {34'd0, ph[29:0]};
    if (ph[30]) u = ONE30 - u;
    u2 = (u * u) >> 30;
    t = poly_coef[5];
    for (int k = 4; k >= 0; k--) t = poly_coef[k] - ((u2 * t) >> 30);
    s = (u * t) >> 30;
    if (s > ONE30) s = ONE30;
    return ph[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic bit [32:0] project(bit [63:0] p, longint signed fa, longint signed fb);
    bit [63:0] ma, mb, f, v;
    ma = fa < 0 ? -fa : fa;
    mb = fb < 0 ? -fb : fb;
    f = (ma * mb + HALF30) >> 30;
    v = (p * f + HALF30) >> 30;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return ((fa < 0) != (fb < 0)) ? 33'(-v) : v[32:0];
  endfunction

  function automatic momentum_word_t predict_momentum(bit [7:0] a, bit [23:0] e,
                                                      bit [15:0] az, bit [15:0] pol);
    momentum_word_t w;
    bit [63:0] m, t, tot, p, c, b;
    bit [127:0] rad;
    longint signed caz, saz, cpol, spol;
    m = a * nucleon_mass_q;
    t = e * a;
    tot = t + m;
    rad = {64'd0, t} * {64'd0, t + 2 * m};
    p = 0;
    for (int i = 35; i >= 0; i--) begin
      c = p | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= rad) p = c;
    end
    caz  = sine_of_turn({az, 16'd0} + 32'h4000_0000);
    saz  = sine_of_turn({az, 16'd0});
    cpol = sine_of_turn({pol, 16'd0} + 32'h4000_0000);
    spol = sine_of_turn({pol, 16'd0});
    b = 0;
    if (tot != 0) begin
      b = (p << 16) / tot;
      if (b > 65536) b = 65536;
    end
    w.px = project(p, caz, spol);
    w.py = project(p, saz, spol);
    w.pz = project(p, cpol, longint'(ONE30));
    w.beta = b[16:0];
    return w;
  endfunction

  // result side: stall pattern plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (idle_mode == IDLE_RECV) begin
        out_ready_i <= ($urandom_range(99) >= 69);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ready_i <= ($urandom_range(99) >= 6);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      momentum_word_t w;
      n_words++;
      if (pending_words.size() == 0) begin
        $error("word with nothing expected");
        n_errors++;
      end else begin
        w = pending_words.pop_front();
        if (momentum_x_o !== w.px) begin
          $error("momentum_x expected %h got %h", w.px, momentum_x_o); n_errors++;
        end
        if (momentum_y_o !== w.py) begin
          $error("momentum_y expected %h got %h", w.py, momentum_y_o); n_errors++;
        end
        if (momentum_z_o !== w.pz) begin
          $error("momentum_z expected %h got %h", w.pz, momentum_z_o); n_errors++;
        end
        if (beta_value_o !== w.beta) begin
          $error("beta_value expected %h got %h", w.beta, beta_value_o); n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_mass(bit [23:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {IDX_NM, 2'b00};
    pwdata <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    nucleon_mass_q = v;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[23:0] !== v) begin
      $error("nucleon_mass readback expected %h got %h", v, prdata[23:0]); n_errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    n_settings++;
  endtask

  task automatic send_particle(stim_row_t r);
    int gap;
    gap = 0;
    if (idle_mode == IDLE_SEND && $urandom_range(99) < 69) gap = $urandom_range(1, 4);
    if (idle_mode == IDLE_BOTH && $urandom_range(99) < 6) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mass_number_i <= r.a;
    energy_per_nucleon_i <= r.e;
    azimuth_angle_i <= r.az;
    polar_angle_i <= r.pol;
    do @(posedge clk_i); while (!in_ready_o);
    pending_words.push_back(r.typed ? r.want : predict_momentum(r.a, r.e, r.az, r.pol));
    n_items++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  function automatic stim_row_t random_particle();
    stim_row_t r;
    r.typed = 1'b0;
    r.want = '{default: 0};
    case ($urandom_range(9))
      0: r.a = 8'd0;
      1: r.a = 8'd255;
      default: r.a = 8'($urandom_range(1, 255));
    endcase
    case ($urandom_range(7))
      0: r.e = 24'($urandom_range(0, 255));
      1: r.e = 24'(24'hFF_FFFF - $urandom_range(0, 15));
      default: r.e = 24'($urandom());
    endcase
    r.az = 16'($urandom());
    r.pol = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    return r;
  endfunction

  stim_row_t directed [] = '{
    '{8'd1,   24'd0,        16'd0,     16'd0,     1'b1, '{0, 0, 0, 0}},
    '{8'd0,   24'hFF_FFFF,  16'd12345, 16'd4000,  1'b1, '{0, 0, 0, 0}},
    '{8'd255, 24'd0,        16'hFFFF,  16'd32768, 1'b1, '{0, 0, 0, 0}},
    '{8'd1,   24'd1,        16'd0,     16'd0,     1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'd0,     16'd0,     1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'd0,     16'd16384, 1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'd16384, 16'd16384, 1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'd32768, 16'd16384, 1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'd49152, 16'd16384, 1'b0, '{0, 0, 0, 0}},
    '{8'd255, 24'hFF_FFFF,  16'hFFFF,  16'd32768, 1'b0, '{0, 0, 0, 0}},
    '{8'd4,   24'd240198,   16'd8192,  16'd8192,  1'b0, '{0, 0, 0, 0}},
    '{8'd12,  24'd25600,    16'd5461,  16'd40000, 1'b0, '{0, 0, 0, 0}},
    '{8'd1,   24'h80_0000,  16'h8000,  16'hFFFF,  1'b0, '{0, 0, 0, 0}},
    '{8'd128, 24'h7F_FFFF,  16'h7FFF,  16'h5555,  1'b0, '{0, 0, 0, 0}},
    '{8'd1,   24'hFF_FFFF,  16'hAAAA,  16'd1,     1'b0, '{0, 0, 0, 0}}
  };

  bit [23:0] mass_plan [6] = '{24'd240198, 24'd1, 24'hFF_FFFF, 24'd0, 24'd0, 24'd240198};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed[i]) send_particle(directed[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_mass(ph == 4 ? 24'($urandom_range(1, 24'hFF_FFFF)) : mass_plan[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      // first setting: long output hold-off while the input keeps offering
      if (ph == 0) hold_left = 300;
      for (int k = 0; k < 200; k++) begin
        if (k == 100 && ph == 2) begin
          // sender pauses until every word is back
          in_valid_i <= 1'b0;
          while (pending_words.size() != 0) @(posedge clk_i);
        end
        send_particle(random_particle());
      end
      drain();
    end

    $display("covered %0d particles, %0d words, %0d nucleon mass settings",
             n_items, n_words, n_settings);
    $display("zero mass and energy, saturating components, all quadrants, idle phases");
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
